// File: design/snd_pkg.sv
// Shared types and constants for the duplicate-rejecting stack.
// No dependencies. The interfaces, the controller and the top level use it.
`default_nettype none

package snd_pkg;

    localparam int SND_DEPTH      = 16;
    localparam int SND_ITEM_WIDTH = 32;
    localparam int CMD_WIDTH      = 2;
    localparam int VALUE_WIDTH    = 32;

    localparam logic [CMD_WIDTH-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_PEEK = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic                   status;
        logic                   already_present;
        logic [VALUE_WIDTH-1:0] top_value;
        logic                   is_empty;
    } t_rsp;

endpackage

`default_nettype wire

// File: design/snd_cmd_if.sv
// Command channel of the stack: valid, ready and one command beat.
// Depends on snd_pkg for the field widths.
`default_nettype none

interface snd_cmd_if;
    import snd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_WIDTH-1:0]   command;
    logic [VALUE_WIDTH-1:0] item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);
endinterface

`default_nettype wire

// File: design/snd_rsp_if.sv
// Response channel of the stack: valid, ready and one result beat.
// Depends on snd_pkg for the field widths.
`default_nettype none

interface snd_rsp_if;
    import snd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   status;
    logic                   already_present;
    logic [VALUE_WIDTH-1:0] top_value;
    logic                   is_empty;

    modport source (output valid, output status, output already_present,
                    output top_value, output is_empty, input ready);
    modport sink   (input valid, input status, input already_present,
                    input top_value, input is_empty, output ready);
endinterface

`default_nettype wire

// File: design/snd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module snd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

`default_nettype wire

// File: design/snd_ctrl.sv
// Stack controller: entry count, duplicate search over the entry RAM,
// push, pop and peek decisions, and the registered response beat.
// Depends on snd_pkg, snd_cmd_if and snd_rsp_if.
`default_nettype none

module snd_ctrl #(
    parameter int DEPTH      = snd_pkg::SND_DEPTH,
    parameter int ITEM_WIDTH = snd_pkg::SND_ITEM_WIDTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    snd_cmd_if.sink                    i_cmd,
    snd_rsp_if.source                  o_rsp,
    output logic                       o_wr_en,
    output logic      [AW-1:0]         o_wr_addr,
    output logic      [ITEM_WIDTH-1:0] o_wr_data,
    output logic                       o_rd_en,
    output logic      [AW-1:0]         o_rd_addr,
    input  wire logic [ITEM_WIDTH-1:0] i_rd_data
);
    import snd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PEEK,
        ST_RESP
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [ITEM_WIDTH-1:0] r_value, n_value;
    t_rsp                  r_res, n_res;
    t_rsp                  r_out, n_out;
    logic                  r_out_valid, n_out_valid;
    logic                  out_free;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_value     = r_value;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_count[AW-1:0];
        o_wr_data   = r_value;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_value               = ITEM_WIDTH'(i_cmd.item_value);
                    n_res.status          = STATUS_FAIL;
                    n_res.already_present = 1'b0;
                    n_res.top_value       = '0;
                    n_res.is_empty        = (r_count == '0);
                    n_state               = ST_RESP;
                    unique case (i_cmd.command)
                        CMD_PUSH: begin
                            if (r_count != '0) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_idx     = '0;
                                n_state   = ST_SEARCH;
                            end else begin
                                o_wr_en        = 1'b1;
                                o_wr_addr      = '0;
                                o_wr_data      = ITEM_WIDTH'(i_cmd.item_value);
                                n_count        = CW'(1);
                                n_res.status   = STATUS_OK;
                                n_res.is_empty = 1'b0;
                            end
                        end
                        CMD_POP: begin
                            if (r_count != '0) begin
                                n_count        = r_count - CW'(1);
                                n_res.status   = STATUS_OK;
                                n_res.is_empty = (r_count == CW'(1));
                            end
                        end
                        CMD_PEEK: begin
                            if (r_count != '0) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(r_count - CW'(1));
                                n_state   = ST_PEEK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (i_rd_data == r_value) begin
                    n_res.status          = STATUS_OK;
                    n_res.already_present = 1'b1;
                    n_state               = ST_RESP;
                end else if ((CW'(r_idx) + CW'(1)) < r_count) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end else if (r_count < CW'(DEPTH)) begin
                    o_wr_en        = 1'b1;
                    n_count        = r_count + CW'(1);
                    n_res.status   = STATUS_OK;
                    n_res.is_empty = 1'b0;
                    n_state        = ST_RESP;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_PEEK: begin
                n_res.status    = STATUS_OK;
                n_res.top_value = VALUE_WIDTH'(i_rd_data);
                n_state         = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx   <= n_idx;
        r_value <= n_value;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.already_present = r_out.already_present;
    assign o_rsp.top_value       = r_out.top_value;
    assign o_rsp.is_empty        = r_out.is_empty;
endmodule

`default_nettype wire

// File: design/stack_no_duplicates_top.sv
// Stack of unique values: push with duplicate search, pop and peek.
// Pop and unused commands are decided in idle; peek first reads the top entry unless the
// stack is empty; push on an empty stack writes at once, and otherwise searches the entry
// RAM one entry per cycle from the bottom, stopping at a match, before it is decided.
// One command is in work at a time; the next is taken once the result is queued.
// Synchronous active-low reset empties the stack; entry contents are not cleared.
`default_nettype none

module stack_no_duplicates_top #(
    parameter int DEPTH      = snd_pkg::SND_DEPTH,
    parameter int ITEM_WIDTH = snd_pkg::SND_ITEM_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    snd_cmd_if.sink   i_cmd,
    snd_rsp_if.source o_rsp
);
    import snd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [ITEM_WIDTH-1:0] rd_data;

    snd_ctrl #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_rsp     (o_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    snd_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );
endmodule

`default_nettype wire

// File: dv/stack_no_duplicates_top_test.sv
// Self-checking test of stack_no_duplicates_top: a directed table, then random command beats.
// Responses are checked against fixed rows, else a shadow stack updated per accepted beat.
// Depends on snd_pkg, snd_cmd_if, snd_rsp_if and the stack_no_duplicates_top design.
`default_nettype none

module stack_no_duplicates_top_test;
    import snd_pkg::*;

    localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 630;
    localparam int POOL_SIZE    = 24;
    localparam int DRAIN_CYCLES = 2 * SND_DEPTH + 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]   command;
        logic [VALUE_WIDTH-1:0] item_value;
        logic                   fixed;
        t_rsp                   rsp;
    } t_dir_row;

    localparam t_rsp NO_RSP = '0;
    localparam int   DIR_ROWS = 25;

    // Rows with fixed set carry their expected response; the others use the shadow stack.
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{CMD_PEEK,   32'h0000_0000, 1'b1, '{STATUS_FAIL, 1'b0, 32'h0000_0000, 1'b1}},
        '{CMD_POP,    32'hFFFF_FFFF, 1'b1, '{STATUS_FAIL, 1'b0, 32'h0000_0000, 1'b1}},
        '{CMD_UNUSED, 32'h0000_0000, 1'b1, '{STATUS_FAIL, 1'b0, 32'h0000_0000, 1'b1}},
        '{CMD_PUSH,   32'h0000_0000, 1'b1, '{STATUS_OK,   1'b0, 32'h0000_0000, 1'b0}},
        '{CMD_PUSH,   32'h0000_0000, 1'b1, '{STATUS_OK,   1'b1, 32'h0000_0000, 1'b0}},
        '{CMD_PUSH,   32'hFFFF_FFFF, 1'b1, '{STATUS_OK,   1'b0, 32'h0000_0000, 1'b0}},
        '{CMD_PEEK,   32'h0000_0000, 1'b1, '{STATUS_OK,   1'b0, 32'hFFFF_FFFF, 1'b0}},
        '{CMD_PUSH,   32'h0000_0001, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h0000_0002, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h8000_0000, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h7FFF_FFFF, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'hAAAA_AAAA, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h5555_5555, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h0000_0003, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h0000_0004, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h0000_0005, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h0000_0006, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h0000_0007, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h0000_0008, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h0000_0009, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h0000_000A, 1'b0, NO_RSP},
        '{CMD_PUSH,   32'h1234_5678, 1'b1, '{STATUS_FAIL, 1'b0, 32'h0000_0000, 1'b0}},
        '{CMD_PUSH,   32'h0000_0000, 1'b1, '{STATUS_OK,   1'b1, 32'h0000_0000, 1'b0}},
        '{CMD_POP,    32'h0000_0000, 1'b0, NO_RSP},
        '{CMD_PEEK,   32'h0000_0000, 1'b0, NO_RSP}
    };

    logic clk;
    logic rst_n;

    snd_cmd_if cmd_if();
    snd_rsp_if rsp_if();

    stack_no_duplicates_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    logic [VALUE_WIDTH-1:0] shadow_entries [SND_DEPTH];
    int                     shadow_count;
    t_rsp                   expected_rsp_q [$];
    int                     fail_count;
    int                     stall_cycles;
    int                     tx_idle_pct;
    int                     rx_idle_pct;
    logic                   beat_fixed;
    t_rsp                   beat_rsp;
    logic [VALUE_WIDTH-1:0] value_pool [POOL_SIZE];

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic t_rsp predict_stack_step(input logic [CMD_WIDTH-1:0] c,
                                                input logic [VALUE_WIDTH-1:0] v);
        t_rsp r;
        bit   found;
        r = '{STATUS_FAIL, 1'b0, '0, 1'b0};
        found = 1'b0;
        case (c)
            CMD_PUSH: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_entries[i] == v) found = 1'b1;
                end
                if (found) begin
                    r.already_present = 1'b1;
                    r.status = STATUS_OK;
                end else if (shadow_count < SND_DEPTH) begin
                    shadow_entries[shadow_count] = v;
                    shadow_count++;
                    r.status = STATUS_OK;
                end
            end
            CMD_POP: begin
                if (shadow_count > 0) begin
                    shadow_count--;
                    r.status = STATUS_OK;
                end
            end
            CMD_PEEK: begin
                if (shadow_count > 0) begin
                    r.top_value = shadow_entries[shadow_count-1];
                    r.status = STATUS_OK;
                end
            end
            default: begin
            end
        endcase
        r.is_empty = (shadow_count == 0);
        return r;
    endfunction

    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && cmd_if.valid && cmd_if.ready) begin
            want = predict_stack_step(cmd_if.command, cmd_if.item_value);
            expected_rsp_q.push_back(beat_fixed ? beat_rsp : want);
        end
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp_q.size() == 0) begin
                $error("unexpected response beat: no expectation waiting");
                fail_count++;
            end else begin
                want = expected_rsp_q.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.already_present !== want.already_present) begin
                    $error("already_present: expected %0d, actual %0d",
                           want.already_present, rsp_if.already_present);
                    fail_count++;
                end
                if (rsp_if.top_value !== want.top_value) begin
                    $error("top_value: expected %08h, actual %08h",
                           want.top_value, rsp_if.top_value);
                    fail_count++;
                end
                if (rsp_if.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp_if.is_empty);
                    fail_count++;
                end
            end
        end
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_beat(input logic [CMD_WIDTH-1:0] c, input logic [VALUE_WIDTH-1:0] v,
                             input logic fixed, input t_rsp r);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= c;
        cmd_if.item_value <= v;
        beat_fixed        <= fixed;
        beat_rsp          <= r;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    initial begin
        logic [CMD_WIDTH-1:0]   c;
        logic [VALUE_WIDTH-1:0] v;
        int                     push_pct;
        int                     run_left;
        int                     roll;
        fail_count        = 0;
        stall_cycles      = 0;
        shadow_count      = 0;
        tx_idle_pct       = 24;
        rx_idle_pct       = 61;
        rst_n             <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.command    <= CMD_PUSH;
        cmd_if.item_value <= '0;
        beat_fixed        <= 1'b0;
        beat_rsp          <= NO_RSP;
        for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(DIRECTED[i].command, DIRECTED[i].item_value,
                      DIRECTED[i].fixed, DIRECTED[i].rsp);
        end

        // Push-heavy and pop-heavy runs alternate so the stack swings between empty and full.
        push_pct = 75;
        run_left = $urandom_range(20, 50);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 61;
                rx_idle_pct = 24;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (run_left == 0) begin
                push_pct = (push_pct > 50) ? 25 : 75;
                run_left = $urandom_range(20, 50);
            end
            run_left--;
            roll = $urandom_range(99);
            if (roll < 3) begin
                c = CMD_UNUSED;
            end else if (roll < 3 + push_pct) begin
                c = CMD_PUSH;
            end else if ($urandom_range(9) < 6) begin
                c = CMD_POP;
            end else begin
                c = CMD_PEEK;
            end
            v = ($urandom_range(9) < 8) ? value_pool[$urandom_range(POOL_SIZE-1)] : $urandom;
            send_beat(c, v, 1'b0, NO_RSP);
        end

        cmd_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_rsp_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
